// File: rtl/core/hashed_banked_deque_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hashed banked deque
// Implication checks that are clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef HASHED_BANKED_DEQUE_TOP_ASSERT_SVH
`define HASHED_BANKED_DEQUE_TOP_ASSERT_SVH

`ifndef SYNTH
// Overlapping implication: cons must hold in the same cycle as ante.
`define HBD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbd: same-cycle check failed");
// Non-overlapping implication: cons must hold in the cycle after ante.
`define HBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbd: next-cycle check failed");
`else
`define HBD_ASSERT_SAME(label, ante, cons)
`define HBD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Operation and status codes and port widths of the hashed banked deque.
// ----------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int PORT_VALUE_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_L = 2'd0,
    FN_PUSH_R = 2'd1,
    FN_POP_L  = 2'd2,
    FN_POP_R  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/hashed_banked_deque_top.sv
// ----------------------------------------------------------------------------
// hashed_banked_deque_top
// Double-ended queue spread over BUCKETS circular bucket buffers, with the
// elements in one store memory and the bucket head/count pairs in a second.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload                   Direction
//  -------   ---------------------   -----------------------   ---------
//  request   start, busy             func, value               in
//  result    done (one-cycle strobe) status, popped_value      out
//
// In the cycle a request is accepted, the bucket is chosen from the left
// or right index and its head/count entry is read from the metadata
// memory. In the following cycle busy is high while the element store is
// written (push) or read (pop) and the metadata entry is written back.
// The result beat appears on the cycle after that, and the next request
// may be accepted in that same cycle. No request is accepted while busy
// is high, as the metadata read-modify-write loop requires.
// Reset is synchronous; the bucket metadata reads as empty through one valid
// bit per bucket, so there is no clearing pass and requests are taken in the
// first cycle after reset. The receiver cannot stall the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_banked_deque_top_assert.svh"

module hashed_banked_deque_top
  import hbd_pkg::*;
#(
  parameter int BUCKETS      = 4,
  parameter int BUCKET_DEPTH = 16,
  parameter int VALUE_WIDTH  = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic [PORT_VALUE_W-1:0] value,
  output logic                         done,
  output logic [STATUS_W-1:0]          status,
  output logic [PORT_VALUE_W-1:0]      popped_value
);

  // Bucket number, slot number and element count widths.
  localparam int BW = $clog2(BUCKETS);
  localparam int SW = $clog2(BUCKET_DEPTH);
  localparam int CW = $clog2(BUCKET_DEPTH + 1);
  // Only the low bits of the value port that fit VALUE_WIDTH are kept.
  localparam int DW = (VALUE_WIDTH < PORT_VALUE_W) ? VALUE_WIDTH : PORT_VALUE_W;
  // The store is addressed by {bucket, slot}.
  localparam int AW = BW + SW;
  localparam int STORE_DEPTH = BUCKETS << SW;
  localparam logic [CW:0]   DEPTH_X   = (CW+1)'(BUCKET_DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(BUCKET_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(BUCKET_DEPTH - 1);
  localparam logic [BW-1:0] LAST_BKT  = BW'(BUCKETS - 1);

  function automatic logic [BW-1:0] go_left(input logic [BW-1:0] b);
    return (b == '0) ? LAST_BKT : b - BW'(1);
  endfunction

  function automatic logic [BW-1:0] go_right(input logic [BW-1:0] b);
    return (b == LAST_BKT) ? '0 : b + BW'(1);
  endfunction

  // Memories: element store and per-bucket {head, count}.
  logic [DW-1:0]      store_mem [STORE_DEPTH];
  logic [SW+CW-1:0]   meta_mem  [BUCKETS];
  logic [BUCKETS-1:0] meta_valid;

  // Side indexes.
  logic [BW-1:0] left_idx;
  logic [BW-1:0] right_idx;

  // Accept stage.
  logic          accept;
  logic [BW-1:0] sel_bkt;

  // Execute stage registers.
  logic          exec;
  func_t         op;
  logic [DW-1:0] val;
  logic [BW-1:0] bkt;
  logic [SW+CW-1:0] meta_rd;
  logic          meta_rd_vld;

  // Execute stage logic.
  logic [SW-1:0] head;
  logic [CW-1:0] cnt;
  logic          is_push;
  logic          op_ok;
  logic [CW:0]   tail_sum;
  logic [CW:0]   tail_wrap;
  logic [SW-1:0] slot;
  logic [SW-1:0] head_next;
  logic [CW-1:0] cnt_next;
  logic [AW-1:0] store_addr;

  // Result registers.
  status_t       status_q;
  logic          pop_ok;
  logic [DW-1:0] store_rd;
  logic [PORT_VALUE_W-1:0] pop_ext;

  // A new request is taken whenever the read-modify-write cycle is free.
  assign busy   = exec;
  assign accept = start && !busy;

  always_comb begin
    unique case (func_t'(func))
      FN_PUSH_L: sel_bkt = left_idx;
      FN_PUSH_R: sel_bkt = right_idx;
      FN_POP_L:  sel_bkt = go_right(left_idx);
      FN_POP_R:  sel_bkt = go_left(right_idx);
      default:   sel_bkt = left_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exec <= 1'b0;
    end else begin
      exec <= accept;
    end
  end

  // Payload of the accepted beat and the registered metadata read.
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= func_t'(func);
      val <= value[DW-1:0];
      bkt <= sel_bkt;
    end
    meta_rd     <= meta_mem[sel_bkt];
    meta_rd_vld <= meta_valid[sel_bkt];
  end

  // A bucket never written since reset is empty with its head at slot zero.
  always_comb begin
    if (meta_rd_vld) begin
      head = meta_rd[SW+CW-1:CW];
      cnt  = meta_rd[CW-1:0];
    end else begin
      head = '0;
      cnt  = '0;
    end
  end

  always_comb begin
    is_push = (op == FN_PUSH_L) || (op == FN_PUSH_R);
    op_ok   = is_push ? (cnt != DEPTH_CNT) : (cnt != '0);

    // Left side works at the tail: head + count, or head + count - 1 on pop.
    tail_sum = (CW+1)'(head) + (CW+1)'(cnt);
    if (op == FN_POP_L) begin
      tail_sum = tail_sum - (CW+1)'(1);
    end
    tail_wrap = (tail_sum >= DEPTH_X) ? tail_sum - DEPTH_X : tail_sum;

    head_next = head;
    unique case (op)
      FN_PUSH_L: begin
        slot = tail_wrap[SW-1:0];
      end
      FN_POP_L: begin
        slot = tail_wrap[SW-1:0];
      end
      FN_PUSH_R: begin
        head_next = (head == '0) ? LAST_SLOT : head - SW'(1);
        slot      = head_next;
      end
      FN_POP_R: begin
        slot      = head;
        head_next = (head == LAST_SLOT) ? '0 : head + SW'(1);
      end
      default: begin
        slot = head;
      end
    endcase

    cnt_next   = is_push ? cnt + CW'(1) : cnt - CW'(1);
    store_addr = {bkt, slot};
  end

  // Element store: at most one access per request, in the execute cycle.
  always_ff @(posedge clk) begin
    if (exec && op_ok) begin
      if (is_push) begin
        store_mem[store_addr] <= val;
      end else begin
        store_rd <= store_mem[store_addr];
      end
    end
  end

  // Metadata write-back. The next request reads it only after the write has
  // taken effect, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (exec && op_ok) begin
      meta_mem[bkt] <= {head_next, cnt_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_valid <= '0;
      left_idx   <= '0;
      right_idx  <= BW'(1 % BUCKETS);
    end else if (exec && op_ok) begin
      meta_valid[bkt] <= 1'b1;
      unique case (op)
        FN_PUSH_L: left_idx  <= go_left(left_idx);
        FN_PUSH_R: right_idx <= go_right(right_idx);
        FN_POP_L:  left_idx  <= bkt;
        FN_POP_R:  right_idx <= bkt;
        default:   left_idx  <= left_idx;
      endcase
    end
  end

  // Result beat, in the cycle after the execute cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      pop_ok <= 1'b0;
    end else begin
      done   <= exec;
      pop_ok <= exec && op_ok && !is_push;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      if (op_ok) begin
        status_q <= ST_OK;
      end else if (is_push) begin
        status_q <= ST_FULL;
      end else begin
        status_q <= ST_EMPTY;
      end
    end
  end

  always_comb begin
    pop_ext         = '0;
    pop_ext[DW-1:0] = store_rd;
  end

  assign status       = status_q;
  assign popped_value = pop_ok ? pop_ext : '0;

  // The execute cycle never runs twice in a row.
  `HBD_ASSERT_NEXT(a_busy_one_cycle, busy, !busy)
  // An accepted request always yields exactly the following execute cycle
  // and then a result beat.
  `HBD_ASSERT_NEXT(a_accept_exec, accept, busy && !done)
  `HBD_ASSERT_NEXT(a_exec_done, exec, done)
  // A bucket can never report more elements than it holds slots.
  `HBD_ASSERT_SAME(a_cnt_bound, exec, cnt <= DEPTH_CNT)
  // Failed operations carry no element.
  `HBD_ASSERT_SAME(a_fail_zero, done && (status != ST_OK), popped_value == '0)

endmodule

`default_nettype wire

// File: test/hashed_banked_deque_top_tb.sv
// ----------------------------------------------------------------------------
// hashed_banked_deque_top_tb
// Self-checking bench for the hashed banked deque. Requests are driven on
// the start/busy handshake in random bursts. A scoreboard mirrors the bucket
// indexes, heads, counts and contents, and checks each result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_banked_deque_top_tb;
  import hbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUCKETS      = 4;
  localparam int BUCKET_DEPTH = 16;
  localparam int VALUE_WIDTH  = 32;

  // Stored values keep only their low VALUE_WIDTH bits.
  localparam logic [PORT_VALUE_W-1:0] VALUE_MASK =
    (VALUE_WIDTH >= PORT_VALUE_W) ? '1 : ((PORT_VALUE_W'(1) << VALUE_WIDTH) - 1);

  localparam int RANDOM_ITEMS = 1650;

  // One predicted result beat.
  typedef struct packed {
    status_t                 st;
    logic [PORT_VALUE_W-1:0] val;
  } deque_outcome_t;

  // Mirrors the deque and holds the results that are still owed by the block.
  class deque_scoreboard;
    int unsigned             left_idx;
    int unsigned             right_idx;
    logic [PORT_VALUE_W-1:0] slots [BUCKETS][BUCKET_DEPTH];
    int unsigned             head [BUCKETS];
    int unsigned             fill [BUCKETS];
    deque_outcome_t          pending_results [$];
    int                      errors;

    function new();
      left_idx  = 0;
      right_idx = 1 % BUCKETS;
      errors    = 0;
      for (int b = 0; b < BUCKETS; b++) begin
        head[b] = 0;
        fill[b] = 0;
      end
    endfunction

    task report(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    // Applies one accepted request to the mirror and queues its result.
    function void note_request(input func_t op, input logic [PORT_VALUE_W-1:0] v);
      deque_outcome_t          res;
      int unsigned             b;
      logic [PORT_VALUE_W-1:0] w;
      w      = v & VALUE_MASK;
      res.st = ST_OK;
      res.val = '0;
      case (op)
        FN_PUSH_L, FN_PUSH_R: begin
          b = (op == FN_PUSH_L) ? left_idx : right_idx;
          if (fill[b] >= BUCKET_DEPTH) begin
            res.st = ST_FULL;
          end else if (op == FN_PUSH_L) begin
            // Left pushes land at the tail, then the left index steps left.
            slots[b][(head[b] + fill[b]) % BUCKET_DEPTH] = w;
            left_idx = (left_idx + BUCKETS - 1) % BUCKETS;
            fill[b]++;
          end else begin
            // Right pushes land in front of the head, then the right index steps right.
            head[b] = (head[b] + BUCKET_DEPTH - 1) % BUCKET_DEPTH;
            slots[b][head[b]] = w;
            right_idx = (right_idx + 1) % BUCKETS;
            fill[b]++;
          end
        end
        FN_POP_L, FN_POP_R: begin
          b = (op == FN_POP_L) ? (left_idx + 1) % BUCKETS
                               : (right_idx + BUCKETS - 1) % BUCKETS;
          if (fill[b] == 0) begin
            res.st = ST_EMPTY;
          end else if (op == FN_POP_L) begin
            res.val = slots[b][(head[b] + fill[b] - 1) % BUCKET_DEPTH];
            left_idx = b;
            fill[b]--;
          end else begin
            res.val = slots[b][head[b]];
            head[b] = (head[b] + 1) % BUCKET_DEPTH;
            right_idx = b;
            fill[b]--;
          end
        end
      endcase
      pending_results.push_back(res);
    endfunction

    // Compares one result beat with the oldest owed result.
    task check_result(input logic [STATUS_W-1:0] st, input logic [PORT_VALUE_W-1:0] pv);
      deque_outcome_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat with no request outstanding (status %0d)", st));
      end else begin
        want = pending_results.pop_front();
        if (st !== want.st)
          report($sformatf("status is %0d, should be %0d", st, want.st));
        if (pv !== want.val)
          report($sformatf("popped_value is %h, should be %h", pv, want.val));
      end
    endtask
  endclass

  logic                    clk   = 1'b0;
  logic                    rst   = 1'b1;
  logic                    start = 1'b0;
  logic [FUNC_W-1:0]       func  = '0;
  logic [PORT_VALUE_W-1:0] value = '0;
  logic                    busy;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic [PORT_VALUE_W-1:0] popped_value;

  deque_scoreboard sb = new();

  hashed_banked_deque_top #(
    .BUCKETS      (BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .value        (value),
    .done         (done),
    .status       (status),
    .popped_value (popped_value)
  );

  // 10 ns clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Upper bound on the whole run. A correct run needs well under a tenth of this.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // Observe both channels at every rising edge. All inputs change by
  // nonblocking assignment, so the values seen here are the ones that were
  // stable during the cycle that the edge closes. A request beat is noted
  // before the result beat is checked, so the queue order never depends on
  // which of the two shows up first at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.note_request(func_t'(func), value);
      if (done)
        sb.check_result(status, popped_value);
    end
  end

  // Presents one request and holds it until the block takes it. The task
  // returns at the edge where the beat was accepted; start stays high, so a
  // following call keeps the request line asserted without a glitch.
  task automatic issue(input func_t op, input logic [PORT_VALUE_W-1:0] v);
    start <= 1'b1;
    func  <= op;
    value <= v;
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  // Drops the request line for a number of cycles. The payload ports carry
  // junk meanwhile, which the block must ignore while start is low.
  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) begin
      func  <= FUNC_W'($urandom);
      value <= $urandom;
      @(posedge clk);
    end
  endtask

  // Chooses an operation; push_pct sets how often it is a push.
  function automatic func_t pick_op(input int unsigned push_pct);
    logic right_side;
    right_side = 1'($urandom_range(1));
    if ($urandom_range(99) < push_pct)
      return right_side ? FN_PUSH_R : FN_PUSH_L;
    return right_side ? FN_POP_R : FN_POP_L;
  endfunction

  // Sends a stretch of random requests in bursts. A push-heavy stretch fills
  // the buckets until pushes get refused, a pop-heavy one drains them until
  // pops come back empty, and the mixed ones wander in between.
  task automatic random_stretch(input int unsigned items, input int unsigned push_pct);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      for (int unsigned k = 0; k < burst && sent < items; k++) begin
        issue(pick_op(push_pct), $urandom);
        sent++;
      end
      // About a quarter of the bursts run straight into the next one.
      if ($urandom_range(3) != 0)
        pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    int unsigned done_items;
    int unsigned stretch;
    int unsigned push_pct;
    int unsigned waited;

    // Synchronous reset, held at the start of the run only.
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening, back to back. From reset the left index is 0 and
    // the right index is 1, so both first pops look at empty buckets.
    issue(FN_POP_L, 32'h0000_0000);
    issue(FN_POP_R, 32'hFFFF_FFFF);
    // Two pushes per side into four different buckets, with the value
    // extremes and both alternating bit patterns. The right pushes make the
    // bucket head wrap below slot zero.
    issue(FN_PUSH_L, 32'h0000_0000);
    issue(FN_PUSH_R, 32'hFFFF_FFFF);
    issue(FN_PUSH_L, 32'hAAAA_AAAA);
    issue(FN_PUSH_R, 32'h5555_5555);
    // Pops undo the pushes in reverse order on each side.
    issue(FN_POP_L, 32'h1234_5678);
    issue(FN_POP_R, 32'h1234_5678);
    issue(FN_POP_L, 32'h0000_0000);
    issue(FN_POP_R, 32'h0000_0000);
    // Everything is gone again, so both sides report empty.
    issue(FN_POP_L, 32'hFFFF_FFFF);
    issue(FN_POP_R, 32'hFFFF_FFFF);
    // A left push reached from the right side, which pops the head of the
    // same bucket.
    issue(FN_PUSH_L, 32'h8000_0001);
    issue(FN_POP_R, 32'h0000_0000);
    // One more push per side; these elements stay for the random part.
    issue(FN_PUSH_R, 32'h7FFF_FFFE);
    issue(FN_PUSH_L, 32'hDEAD_BEEF);
    pause(3);

    // Random part, in stretches that lean toward filling or draining.
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      stretch = $urandom_range(40, 120);
      if (stretch > RANDOM_ITEMS - done_items)
        stretch = RANDOM_ITEMS - done_items;
      case ($urandom_range(3))
        0:       push_pct = 90;
        1:       push_pct = 10;
        2:       push_pct = 50;
        default: push_pct = 70;
      endcase
      random_stretch(stretch, push_pct);
      done_items += stretch;
    end
    pause(1);

    // Let the last result beats drain before deciding.
    waited = 0;
    while (sb.pending_results.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d result beats never arrived", sb.pending_results.size()));

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/hbd_pkg.sv
rtl/core/hashed_banked_deque_top.sv
test/hashed_banked_deque_top_tb.sv
